// ----- hw/rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// deq_pkg: shared types and codes for the double-ended queue unit
// no dependencies

package deq_pkg;

   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK          = 2'd0,
      ST_EMPTY_ERROR = 2'd1,
      ST_FULL_ERROR  = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture request, start slot read
      logic execute;  // update pointers, write slot, load response register
   } deq_cmd_type;

endpackage

// ----- hw/rtl/deq_req_if.sv -----
`timescale 1ns / 1ps
// deq_req_if: request channel of the double-ended queue unit
// depends on deq_pkg

interface deq_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   import deq_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_WIDTH-1:0]          operation;
   logic signed [DATA_WIDTH-1:0] data_in;

   modport source (output valid, output operation, output data_in, input ready);
   modport sink   (input valid, input operation, input data_in, output ready);
endinterface

// ----- hw/rtl/deq_rsp_if.sv -----
`timescale 1ns / 1ps
// deq_rsp_if: response channel of the double-ended queue unit
// depends on deq_pkg

interface deq_rsp_if #(
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 5
) ();
   import deq_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] data_out;
   logic [STATUS_WIDTH-1:0]      status;
   logic [COUNT_WIDTH-1:0]       item_count;
   logic                         is_empty;

   modport source (output valid, output data_out, output status, output item_count,
                   output is_empty, input ready);
   modport sink   (input valid, input data_out, input status, input item_count,
                   input is_empty, output ready);
endinterface

// ----- hw/rtl/deq_ctrl.sv -----
`timescale 1ns / 1ps
// deq_ctrl: request sequencing and response valid for the queue unit
// depends on deq_pkg

module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output deq_pkg::deq_cmd_type  cmd
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // take a request only when the response register is free or draining
   assign req_ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign cmd.load    = req_valid && req_ready;
   assign cmd.execute = (state_ff == S_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/deq_dp.sv -----
`timescale 1ns / 1ps
// deq_dp: ring buffer storage, pointers, count and response register
// depends on deq_pkg

module deq_dp #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  deq_pkg::deq_cmd_type                  cmd,
   input  logic [deq_pkg::OP_WIDTH-1:0]          req_operation,
   input  logic signed [DATA_WIDTH-1:0]          req_data_in,
   output logic signed [DATA_WIDTH-1:0]          rsp_data_out,
   output logic [deq_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_item_count,
   output logic                                  rsp_is_empty
);
   import deq_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   logic signed [DATA_WIDTH-1:0] slots_mem [DEPTH];

   logic [PTR_W-1:0]             front_ff, front_in;
   logic [PTR_W-1:0]             back_ff, back_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic [OP_WIDTH-1:0]          op_ff;
   logic signed [DATA_WIDTH-1:0] word_ff;
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic signed [DATA_WIDTH-1:0] data_out_ff;
   logic [STATUS_WIDTH-1:0]      status_ff;
   logic [COUNT_W-1:0]           item_count_ff;
   logic                         is_empty_ff;

   logic [PTR_W-1:0]             rd_addr;
   logic [PTR_W-1:0]             wr_addr;
   logic                         wr_en;
   logic signed [DATA_WIDTH-1:0] data_res;
   status_type                   status_res;
   logic                         full;
   logic                         empty;

   assign full  = (count_ff == COUNT_FULL);
   assign empty = (count_ff == '0);

   // back-end reads look at the slot before the back pointer
   assign rd_addr = (req_operation == OP_POP_BACK || req_operation == OP_PEEK_BACK)
                    ? ptr_prev(back_ff) : front_ff;

   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = back_ff;
      data_res   = '0;
      status_res = ST_OK;
      unique case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_res = ST_FULL_ERROR;
            end else begin
               front_in = ptr_prev(front_ff);
               wr_addr  = front_in;
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_res = ST_FULL_ERROR;
            end else begin
               wr_addr  = back_ff;
               wr_en    = 1'b1;
               back_in  = ptr_next(back_ff);
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (empty) begin
               status_res = ST_EMPTY_ERROR;
            end else begin
               data_res = rd_data_ff;
               if (op_ff == OP_POP_FRONT) begin
                  front_in = ptr_next(front_ff);
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (empty) begin
               status_res = ST_EMPTY_ERROR;
            end else begin
               data_res = rd_data_ff;
               if (op_ff == OP_POP_BACK) begin
                  back_in  = ptr_prev(back_ff);
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_data_ff <= slots_mem[rd_addr];
      end
      if (cmd.execute && wr_en) begin
         slots_mem[wr_addr] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         word_ff <= req_data_in;
      end
      if (cmd.execute) begin
         data_out_ff   <= data_res;
         status_ff     <= status_res;
         item_count_ff <= count_in;
         is_empty_ff   <= (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   assign rsp_data_out   = data_out_ff;
   assign rsp_status     = status_ff;
   assign rsp_item_count = item_count_ff;
   assign rsp_is_empty   = is_empty_ff;

endmodule

// ----- hw/rtl/double_ended_queue_unit.sv -----
`timescale 1ns / 1ps
// double_ended_queue_unit: bounded deque of signed words in a ring buffer
// a request is accepted in S_IDLE, where the slot read is registered, and executes in S_EXEC;
// a new one is taken only after that and while the response register is free or draining
// reset: synchronous, active high; clears pointers, count and handshake state
// slot storage is not cleared, entries are only read after they were written
// depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ctrl, deq_dp

module double_ended_queue_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_ch,
   deq_rsp_if.source  rsp_ch
);
   import deq_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);

   // command bundle from the sequencer into the datapath
   deq_cmd_type cmd;

   // controller: S_IDLE accepts the request and starts the slot read,
   // S_EXEC executes the operation and loads the response register;
   // a new request is taken while the response register drains
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // datapath: front/back pointers, stored count, slot memory,
   // error checks and the response payload register
   deq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_ch.operation),
      .req_data_in    (req_ch.data_in),
      .rsp_data_out   (rsp_ch.data_out),
      .rsp_status     (rsp_ch.status),
      .rsp_item_count (rsp_ch.item_count),
      .rsp_is_empty   (rsp_ch.is_empty)
   );

`ifndef ASSERT_OFF
   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   // every accepted request yields a response once it has executed
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> ##2 rsp_ch.valid)
      else $error("response missing after accepted request");

   // reported count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.item_count <= COUNT_W'(DEPTH))
      else $error("item count above capacity");

   // empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.is_empty == (rsp_ch.item_count == '0))
      else $error("empty flag disagrees with item count");
`endif

endmodule
